FILE: rtl/core/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg : shared types and constants for the lookahead point unit
// Datapath widths, result codes and sequencer states.
// ----------------------------------------------------------------------------
package ppl_pkg;

  localparam int unsigned XW         = 42;   // extended coordinate width
  localparam int unsigned BisectSteps = 40;
  localparam logic [63:0] CurvEps    = 64'd4294967;

  typedef enum logic [1:0] {
    HOW_FIRST  = 2'd0,
    HOW_SEG    = 2'd1,
    HOW_LAST   = 2'd2,
    HOW_EXTRAP = 2'd3
  } how_e;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MAGX   = 9'b000000010,
    S_SQX    = 9'b000000100,
    S_SQY    = 9'b000001000,
    S_TEST   = 9'b000010000,
    S_EXDIV  = 9'b000100000,
    S_EXMUL  = 9'b001000000,
    S_CURV   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  // serial multiplier control
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

endpackage

FILE: rtl/core/ppl_sermul.sv
// ----------------------------------------------------------------------------
// ppl_sermul : bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ppl_sermul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           busy_o,
  output logic [2*W-1:0] p_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2*W-1:0] acc_q, acc_d, a_q, a_d;
  logic [W-1:0]   b_q, b_d;

  always_comb begin
    cnt_d = cnt_q; acc_d = acc_q; a_d = a_q; b_d = b_q;
    if (start_i) begin
      cnt_d = CW'(W); acc_d = '0; a_d = {{W{1'b0}}, a_i}; b_d = b_i;
    end else if (cnt_q != '0) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end

  // busy from the count only, so a start may be issued on the idle flag
  assign busy_o = (cnt_q != '0);
  assign p_o    = acc_q;
endmodule

FILE: rtl/core/ppl_serdiv.sv
// ----------------------------------------------------------------------------
// ppl_serdiv : restoring divider, one quotient bit per cycle
// Quotient is floor(n / d), built from the most significant bit down.
// ----------------------------------------------------------------------------
module ppl_serdiv #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] d_i,
  output logic         busy_o,
  output logic [W-1:0] q_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d, d_q, d_d;
  logic [W:0]    r_q, r_d, tr;

  always_comb begin
    cnt_d = cnt_q; q_d = q_q; r_d = r_q; d_d = d_q;
    tr = '0;
    if (start_i) begin
      cnt_d = CW'(W); q_d = n_i; r_d = '0; d_d = d_i;
    end else if (cnt_q != '0) begin
      tr = {r_q[W-1:0], q_q[W-1]};
      q_d = q_q << 1;
      if (tr >= {1'b0, d_q}) begin
        tr = tr - {1'b0, d_q};
        q_d[0] = 1'b1;
      end
      r_d   = tr;
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
  end

  assign busy_o = (cnt_q != '0) || start_i;
  assign q_o    = q_q;
endmodule

FILE: rtl/core/pure_pursuit_lookahead_point_unit.sv
// ----------------------------------------------------------------------------
// pure_pursuit_lookahead_point_unit : carrot selector for pure pursuit
// Streams path points, finds the lookahead point and its curvature.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one path point per item,
//   with its lookahead radius and a last-point flag. The output channel
//   (out_valid_o / out_stall_i) carries at most one carrot item per point.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the single
//   extrapolation-enable bit; write it only while the block is idle.
// Sequence:
//   One test pass takes the magnitudes, runs two bit-serial squares and
//   compares; a point without a result needs only that pass.
//   A carrot at the first or last point adds a curvature pass and a division
//   (no division when the distance is tiny). A segment crossing first runs 41
//   bisection passes; an extrapolation adds a division and two serial
//   multiplies before them. All passes share the one bit-serial multiplier
//   and divider.
// Reset clears the previous point, the found flag and the enable bit.
// A stalled result is held in the output register; the input stays stalled
// until that result leaves.
// ----------------------------------------------------------------------------
module pure_pursuit_lookahead_point_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [30:0] lookahead_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] carrot_x_o,
  output logic [31:0] carrot_y_o,
  output logic [31:0] curvature_o,
  output logic [1:0]  how_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import ppl_pkg::*;

  localparam int unsigned CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic signed [XW-1:0] SatHi = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SatLo = -XW'(64'sd1 <<< (CW - 1));

  // phases of the shared test: what to do after x^2+y^2 is known
  typedef enum logic [2:0] {
    P_POINT  = 3'b001,
    P_BISECT = 3'b010,
    P_CURV   = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic cfg_en_q;
  logic found_q, have_prev_q;
  logic signed [XW-1:0] prev_x_q, prev_y_q;

  // working registers
  logic signed [XW-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q, tx_q, ty_q;
  logic signed [XW-1:0] dx_q, dy_q;
  logic [30:0] l_q;
  logic        last_q;
  logic [63:0] l2_q, sx_q;
  logic        big_q;
  logic [5:0]  step_q;
  logic [1:0]  how_q;
  logic        ex_y_q;

  logic [31:0] rx_q, ry_q, rc_q;
  logic [1:0]  rh_q;
  logic        ov_q;

  // shared bit-serial multiplier
  logic        mul_start, mul_busy;
  logic [31:0] ma, mb;
  logic [63:0] mp;
  ppl_sermul #(.W(32)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .busy_o(mul_busy), .p_o(mp)
  );

  // shared serial divider, wide enough for |y| * 2^33
  logic        dv_start, dv_busy;
  logic [64:0] dv_n, dv_d, dv_q;
  ppl_serdiv #(.W(65)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .n_i(dv_n), .d_i(dv_d),
    .busy_o(dv_busy), .q_o(dv_q)
  );

  function automatic logic [XW-1:0] magf(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(-v) : v;
  endfunction
  function automatic logic signed [XW-1:0] sext_in(input logic [31:0] v);
    logic [31:0] m;
    m = v << (32 - CW);
    return XW'($signed(m) >>> (32 - CW));
  endfunction
  function automatic logic signed [XW-1:0] half(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
    logic signed [XW:0] s;
    s = {a[XW-1], a} + {b[XW-1], b};
    return s[XW:1];
  endfunction
  function automatic logic signed [XW-1:0] sat(input logic signed [XW-1:0] v);
    return (v > SatHi) ? SatHi : ((v < SatLo) ? SatLo : v);
  endfunction

  logic [XW-1:0] mtx, mty, mdx, mdy, gmag;
  logic signed [XW-1:0] mx, my;
  logic in_acc, out_acc, in_circle;
  logic [63:0] d2;
  logic [XW-1:0] ex_mag;
  logic signed [XW-1:0] ex_step;

  assign mtx = magf(tx_q);
  assign mty = magf(ty_q);
  assign mdx = magf(dx_q);
  assign mdy = magf(dy_q);
  assign gmag = (mdx > mdy) ? mdx : mdy;
  assign mx = half(ax_q, bx_q);
  assign my = half(ay_q, by_q);
  assign d2 = sx_q + mp;
  assign in_circle = !big_q && (d2 < l2_q);

  // extrapolation step: |d| * floor(2L/g) + |d| = |d| * m, signed back
  assign ex_mag  = XW'(mp) + (ex_y_q ? mdy : mdx);
  assign ex_step = (ex_y_q ? dy_q[XW-1] : dx_q[XW-1]) ? -$signed(ex_mag)
                                                      : $signed(ex_mag);

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    mul_start = 1'b0;
    ma = mtx[31:0];
    mb = mtx[31:0];
    dv_start = 1'b0;
    dv_n = '0;
    dv_d = '0;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MAGX;
      S_MAGX: begin
        mul_start = 1'b1;
        state_d = S_SQX;
      end
      S_SQX: if (!mul_busy) begin
        mul_start = 1'b1;
        ma = mty[31:0];
        mb = mty[31:0];
        state_d = S_SQY;
      end
      S_SQY: if (!mul_busy) state_d = S_TEST;
      S_TEST:  state_d = S_MAGX;  // resolved by the phase case below
      // quotient ready: multiply |dx| by it
      S_EXDIV: if (!dv_busy) begin
        mul_start = 1'b1;
        ma = mdx[31:0];
        mb = dv_q[31:0];
        state_d = S_EXMUL;
      end
      // x product ready: multiply |dy|; y product ready: start bisecting
      S_EXMUL: if (!mul_busy) begin
        if (ex_y_q) state_d = S_MAGX;
        else begin
          mul_start = 1'b1;
          ma = mdy[31:0];
          mb = dv_q[31:0];
        end
      end
      S_CURV: if (!dv_busy) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_TEST) begin
      unique case (phase_q)
        P_POINT: begin
          if (found_q) state_d = S_IDLE;
          else if (!in_circle) begin
            if (have_prev_q) begin
              phase_d = P_BISECT;
              state_d = S_MAGX;
            end else begin
              phase_d = P_CURV;
              state_d = S_MAGX;
            end
          end else if (last_q) begin
            if (cfg_en_q && have_prev_q) begin
              dv_start = 1'b1;
              dv_n = {33'd0, l_q, 1'b0};
              // a zero direction counts as (1,0)
              dv_d = (gmag == '0) ? 65'd1 : {23'd0, gmag};
              state_d = S_EXDIV;
            end else begin
              phase_d = P_CURV;
              state_d = S_MAGX;
            end
          end else state_d = S_IDLE;
        end
        P_BISECT: begin
          if (step_q == 6'(BisectSteps)) begin
            phase_d = P_CURV;
            state_d = S_MAGX;
          end else state_d = S_MAGX;
        end
        P_CURV: begin
          if (d2 <= CurvEps) state_d = S_OUT;
          else begin
            dv_start = 1'b1;
            dv_n = {mty[31:0], 33'd0};
            dv_d = {1'b0, d2};
            state_d = S_CURV;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
    if (state_q == S_IDLE) phase_d = P_POINT;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        px_q <= sext_in(point_x_i);
        py_q <= sext_in(point_y_i);
        tx_q <= sext_in(point_x_i);
        ty_q <= sext_in(point_y_i);
        l_q  <= lookahead_i;
        l2_q <= {33'd0, lookahead_i} * {33'd0, lookahead_i};
        last_q <= last_point_i;
        dx_q <= sext_in(point_x_i) - prev_x_q;
        dy_q <= sext_in(point_y_i) - prev_y_q;
        step_q <= '0;
      end
      S_MAGX: big_q <= (mtx >= XW'(64'd1 << 31)) || (mty >= XW'(64'd1 << 31));
      S_SQX:  if (!mul_busy) sx_q <= mp;
      S_TEST: begin
        if (phase_q == P_POINT) begin
          if (dx_q == '0 && dy_q == '0) dx_q <= XW'(1);
          if (!in_circle && have_prev_q) begin
            ax_q <= prev_x_q; ay_q <= prev_y_q;
            bx_q <= px_q;     by_q <= py_q;
            tx_q <= half(prev_x_q, px_q);
            ty_q <= half(prev_y_q, py_q);
            how_q <= HOW_SEG;
          end else if (!in_circle) begin
            how_q <= HOW_FIRST;
            tx_q <= sat(px_q); ty_q <= sat(py_q);
          end else if (cfg_en_q && have_prev_q) begin
            how_q <= HOW_EXTRAP;
          end else begin
            how_q <= HOW_LAST;
            tx_q <= sat(px_q); ty_q <= sat(py_q);
          end
        end else if (phase_q == P_BISECT) begin
          if (step_q != 6'(BisectSteps)) begin
            if (in_circle) begin ax_q <= tx_q; ay_q <= ty_q; end
            else           begin bx_q <= tx_q; by_q <= ty_q; end
            step_q <= step_q + 6'd1;
            if (step_q + 6'd1 == 6'(BisectSteps)) begin
              tx_q <= sat(in_circle ? bx_q : tx_q);
              ty_q <= sat(in_circle ? by_q : ty_q);
            end else if (in_circle) begin
              tx_q <= half(tx_q, bx_q); ty_q <= half(ty_q, by_q);
            end else begin
              tx_q <= half(ax_q, tx_q); ty_q <= half(ay_q, ty_q);
            end
          end
        end
      end
      S_EXDIV: ex_y_q <= 1'b0;
      S_EXMUL: if (!mul_busy) begin
        if (!ex_y_q) begin
          ax_q <= px_q; ay_q <= py_q;
          bx_q <= px_q + ex_step;
          ex_y_q <= 1'b1;
        end else begin
          by_q <= py_q + ex_step;
          tx_q <= half(px_q, bx_q);
          ty_q <= half(py_q, py_q + ex_step);
        end
      end
      default: ;
    endcase
  end

  // state and phase registers, with bisect-phase entry after extrapolation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= P_POINT;
    end else begin
      state_q <= state_d;
      phase_q <= (state_q == S_EXMUL) ? P_BISECT : phase_d;
    end
  end

  // curvature result: q = floor(|y| * 2^33 / d2), saturate
  logic [31:0] curv_v;
  logic neg_y;
  assign neg_y = ty_q[XW-1];
  always_comb begin
    if (neg_y) curv_v = (dv_q >= 65'h8000_0000) ? 32'h8000_0000 : 32'(-dv_q);
    else       curv_v = (dv_q >= 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q[31:0];
  end

  // path state, enable bit and output valid: advance the previous point, drop it after the last point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_en_q <= 1'b0;
      found_q <= 1'b0;
      have_prev_q <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cfg_en_q <= cfg_data_i;
      if (out_acc) out_valid_o <= 1'b0;
      else if (state_q == S_OUT) out_valid_o <= 1'b1;
      if (state_q == S_TEST && phase_q == P_POINT) begin
        if (last_q) begin
          prev_x_q <= '0; prev_y_q <= '0; have_prev_q <= 1'b0; found_q <= 1'b0;
        end else begin
          prev_x_q <= px_q; prev_y_q <= py_q; have_prev_q <= 1'b1;
          if (!in_circle) found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_TEST && phase_q == P_CURV) ov_q <= (d2 <= CurvEps);
    if (state_q == S_OUT) begin
      rx_q <= tx_q[31:0];
      ry_q <= ty_q[31:0];
      rc_q <= ov_q ? 32'd0 : curv_v;
      rh_q <= how_q;
    end
  end
  assign carrot_x_o  = rx_q;
  assign carrot_y_o  = ry_q;
  assign curvature_o = rc_q;
  assign how_found_o = rh_q;
endmodule

FILE: rtl/core/ppl_checker.sv
// ----------------------------------------------------------------------------
// ppl_checker : port-level checks for the lookahead point unit
// Handshake holding and flow checks, bound to the top level.
// ----------------------------------------------------------------------------
module ppl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] carrot_x_o,
  input logic [1:0]  how_found_o
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(carrot_x_o)
                                 && $stable(how_found_o))
    else $error("stalled result changed");

  // no new item while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // an accepted item keeps the input stalled next cycle
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("back-to-back accept");
endmodule

bind pure_pursuit_lookahead_point_unit ppl_checker u_ppl_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .carrot_x_o, .how_found_o
);
